/* rtl/utf32_to_utf8_converter_defines.svh */
// Assertion macros for the UTF-32 to UTF-8 converter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef UTF32_TO_UTF8_CONVERTER_DEFINES_SVH
`define UTF32_TO_UTF8_CONVERTER_DEFINES_SVH

// same-cycle implication
`define U32U8_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U32U8_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/u32u8_pkg.sv */
// Shared types and constants for the UTF-32 to UTF-8 converter.
// No dependencies.
package u32u8_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] BOM_LE     = 32'hFFFE_0000;
  localparam logic [31:0] BOM_BE     = 32'h0000_FEFF;
  localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
  localparam logic [31:0] CP_4B_MIN  = 32'h0001_0000;
  localparam logic [31:0] CP_3B_MAX  = 32'h0000_FFFF;
  localparam logic [31:0] CP_3B_MIN  = 32'h0000_0800;
  localparam logic [31:0] CP_2B_MAX  = 32'h0000_07FF;
  localparam logic [31:0] CP_2B_MIN  = 32'h0000_0080;

  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] CONT  = 8'h80;

  typedef enum logic [1:0] {
    PH_BOM,
    PH_CONV,
    PH_IGNORE
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       bom_error;
  } out_word_t;

  typedef struct packed {
    logic            err;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } job_t;

endpackage

/* rtl/u32u8_front.sv */
// Front end: byte-order mark check, unit assembly and UTF-8 classification.
// Depends on u32u8_pkg.
module u32u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u32u8_pkg::in_word_t in_data,
  input  logic                q_full,
  output logic                q_push,
  output u32u8_pkg::job_t     q_data
);

  u32u8_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [31:0]       asm_r, asm_nxt;
  logic              le_r, le_nxt;

  function automatic u32u8_pkg::job_t encode(input logic [31:0] c);
    u32u8_pkg::job_t j;
    j     = '0;
    if (c >= u32u8_pkg::CP_4B_MIN && c <= u32u8_pkg::CP_MAX) begin
      j.bytes[0] = u32u8_pkg::LEAD4 | c[25:18];
      j.bytes[1] = u32u8_pkg::CONT | {2'b00, c[17:12]};
      j.bytes[2] = u32u8_pkg::CONT | {2'b00, c[11:6]};
      j.bytes[3] = u32u8_pkg::CONT | {2'b00, c[5:0]};
      j.last_idx = 2'd3;
    end else if (c >= u32u8_pkg::CP_3B_MIN && c <= u32u8_pkg::CP_3B_MAX) begin
      j.bytes[0] = u32u8_pkg::LEAD3 | {4'b0000, c[15:12]};
      j.bytes[1] = u32u8_pkg::CONT | {2'b00, c[11:6]};
      j.bytes[2] = u32u8_pkg::CONT | {2'b00, c[5:0]};
      j.last_idx = 2'd2;
    end else if (c >= u32u8_pkg::CP_2B_MIN && c <= u32u8_pkg::CP_2B_MAX) begin
      j.bytes[0] = u32u8_pkg::LEAD2 | {3'b000, c[10:6]};
      j.bytes[1] = u32u8_pkg::CONT | {2'b00, c[5:0]};
      j.last_idx = 2'd1;
    end else begin
      j.bytes[0] = c[7:0];
      j.last_idx = 2'd0;
    end
    return j;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= u32u8_pkg::PH_BOM;
      cnt_r   <= 2'd0;
      asm_r   <= 32'd0;
      le_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      asm_r   <= asm_nxt;
      le_r    <= le_nxt;
    end
  end

  always_comb begin
    u32u8_pkg::phase_t ph;
    logic [1:0]        cnt;
    logic [31:0]       asm_v;
    logic [31:0]       shifted;
    logic              full;
    logic              accept;

    in_ready  = !q_full;
    accept    = in_valid && in_ready;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    asm_nxt   = asm_r;
    le_nxt    = le_r;
    q_push    = 1'b0;
    q_data    = '0;

    ph    = in_data.stream_start ? u32u8_pkg::PH_BOM : phase_r;
    cnt   = in_data.stream_start ? 2'd0 : cnt_r;
    asm_v = in_data.stream_start ? 32'd0 : asm_r;
    full  = (cnt == 2'd3);

    if (accept) begin
      phase_nxt = ph;
      cnt_nxt   = cnt;
      asm_nxt   = asm_v;
      case (ph)
        u32u8_pkg::PH_BOM: begin
          shifted = {asm_v[23:0], in_data.in_byte};
          cnt_nxt = cnt + 2'd1;
          asm_nxt = shifted;
          if (full) begin
            asm_nxt = 32'd0;
            if (shifted == u32u8_pkg::BOM_LE) begin
              le_nxt    = 1'b1;
              phase_nxt = u32u8_pkg::PH_CONV;
            end else if (shifted == u32u8_pkg::BOM_BE) begin
              le_nxt    = 1'b0;
              phase_nxt = u32u8_pkg::PH_CONV;
            end else begin
              phase_nxt       = u32u8_pkg::PH_IGNORE;
              q_push          = 1'b1;
              q_data.err      = 1'b1;
              q_data.last_idx = 2'd0;
            end
          end
        end
        u32u8_pkg::PH_CONV: begin
          shifted = le_r ? {in_data.in_byte, asm_v[31:8]} : {asm_v[23:0], in_data.in_byte};
          cnt_nxt = cnt + 2'd1;
          asm_nxt = shifted;
          if (full) begin
            asm_nxt = 32'd0;
            q_push  = 1'b1;
            q_data  = encode(shifted);
          end
        end
        default: begin
          shifted = asm_v;
        end
      endcase
    end else begin
      shifted = asm_r;
    end
  end

endmodule

/* rtl/u32u8_queue.sv */
// Small register queue of encoded jobs between front and back end.
// Depends on u32u8_pkg.
module u32u8_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  u32u8_pkg::job_t               push_data,
  output logic                          full,
  input  logic                          pop,
  output logic                          valid,
  output u32u8_pkg::job_t               data,
  output logic [u32u8_pkg::QCNT_W-1:0]  count
);

  localparam logic [u32u8_pkg::QPTR_W-1:0] PTR_LAST =
    u32u8_pkg::QPTR_W'(u32u8_pkg::QUEUE_DEPTH - 1);
  localparam logic [u32u8_pkg::QCNT_W-1:0] CNT_FULL =
    u32u8_pkg::QCNT_W'(u32u8_pkg::QUEUE_DEPTH);

  u32u8_pkg::job_t                mem_r [u32u8_pkg::QUEUE_DEPTH];
  logic [u32u8_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [u32u8_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [u32u8_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                           do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign valid   = (count_r != '0);
  assign data    = mem_r[rd_ptr_r];
  assign count   = count_r;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/u32u8_back.sv */
// Back end: serializes one job into UTF-8 words through an output register.
// Depends on u32u8_pkg.
module u32u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  u32u8_pkg::job_t      q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u32u8_pkg::out_word_t out_data
);

  logic                 busy_r, busy_nxt;
  u32u8_pkg::job_t      job_r;
  logic [1:0]           idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  u32u8_pkg::out_word_t out_r, out_nxt;
  logic                 emit, last_emit;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    emit          = busy_r && (!out_valid_r || out_ready);
    last_emit     = emit && (idx_r == job_r.last_idx);
    q_pop         = q_valid && (!busy_r || last_emit);
    busy_nxt      = q_pop ? 1'b1 : (last_emit ? 1'b0 : busy_r);
    idx_nxt       = q_pop ? 2'd0 : (emit ? idx_r + 2'd1 : idx_r);
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_nxt       = out_r;
    if (emit) begin
      out_nxt.out_byte  = job_r.bytes[idx_r];
      out_nxt.out_last  = (idx_r == job_r.last_idx);
      out_nxt.bom_error = job_r.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (q_pop) begin
      job_r <= q_data;
    end
  end

endmodule

/* rtl/utf32_to_utf8_converter.sv */
// A completed unit is registered in the job queue, then the job and output registers.
// Throughput: one word in per cycle if the queue has room, one out per cycle if out_ready; 1 to 4 out per unit.
// The front end stalls only when the 4-entry job queue is full.
// Reset (rst_n low, synchronous) returns to awaiting the byte-order mark and
// empties the queue and output register.
module utf32_to_utf8_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u32u8_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u32u8_pkg::out_word_t out_data
);

  `include "utf32_to_utf8_converter_defines.svh"

  logic                          q_full, q_push, q_pop, q_valid;
  u32u8_pkg::job_t               q_wdata, q_rdata;
  logic [u32u8_pkg::QCNT_W-1:0]  q_count;

  u32u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  u32u8_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_rdata),
    .count     (q_count)
  );

  u32u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `U32U8_ASSERT_IMP(a_start_no_job, in_valid && in_ready && in_data.stream_start, !q_push, "stream start produced a job")
  `U32U8_ASSERT_IMP(a_err_word, out_valid && out_data.bom_error, out_data.out_last && out_data.out_byte == 8'd0, "malformed error word")
  `U32U8_ASSERT_NXT(a_no_overflow, q_push && q_full, 1'b0, "push into full queue")
  `U32U8_ASSERT_IMP(a_count_valid, q_count != '0, q_valid, "queue count without valid job")

endmodule
